[hdl/mvst_pkg.sv]
// Shared types and constants for the MIDI voice slot tracker.
// No dependencies; imported by mvst_slot_table and midi_voice_slot_tracker_unit.
package mvst_pkg;

  localparam int VOICES_DEF = 8;
  localparam int CMD_W      = 2;
  localparam int BYTE_W     = 8;
  localparam int NOTE_W     = 7;
  localparam int CHAN_W     = 4;
  localparam int SLOT_W     = 3;
  localparam int MASK_W     = 8;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  localparam logic [BYTE_W-1:0] NOTE_MAX = 8'd127;
  localparam logic [BYTE_W-1:0] CHAN_MAX = 8'd15;

  typedef enum logic [CMD_W-1:0] {
    CMD_REGISTER   = 2'd0,
    CMD_UNREGISTER = 2'd1,
    CMD_CLEAR      = 2'd2
  } cmd_t;

  typedef struct packed {
    logic              accepted;
    logic [SLOT_W-1:0] matched_slot;
    logic              free_valid;
    logic [SLOT_W-1:0] free_slot;
    logic [MASK_W-1:0] active_mask;
  } res_t;

endpackage

[hdl/mvst_slot_table.sv]
// Voice slot storage plus the per-command lookup and update logic.
// Depends on mvst_pkg; instantiated by midi_voice_slot_tracker_unit.
module mvst_slot_table #(
  parameter int VOICES = mvst_pkg::VOICES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        commit,
  input  mvst_pkg::cmd_t              cmd,
  input  logic [mvst_pkg::BYTE_W-1:0] note_number,
  input  logic [mvst_pkg::BYTE_W-1:0] midi_chan,
  input  logic [mvst_pkg::BYTE_W-1:0] voice_slot,
  output mvst_pkg::res_t              res
);
  import mvst_pkg::*;

  logic [VOICES-1:0] active_r;
  logic [VOICES-1:0] active_nxt;
  logic [NOTE_W-1:0] note_r [VOICES];
  logic [CHAN_W-1:0] chan_r [VOICES];

  logic              fields_ok;
  logic              slot_ok;
  logic [VOICES-1:0] slot_sel;
  logic [VOICES-1:0] hit;
  logic [VOICES-1:0] wr_sel;
  logic              found;
  logic [SLOT_W-1:0] hit_idx;

  always_comb begin
    fields_ok = (note_number <= NOTE_MAX) && (midi_chan <= CHAN_MAX);
    slot_ok   = voice_slot < BYTE_W'(VOICES);
    for (int i = 0; i < VOICES; i++) begin
      slot_sel[i] = voice_slot == BYTE_W'(i);
      hit[i] = active_r[i] && ({1'b0, note_r[i]} == note_number) &&
               ({4'b0, chan_r[i]} == midi_chan);
    end
    // lowest matching slot wins: scan downward so the last hit kept is lowest
    found   = 1'b0;
    hit_idx = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found   = 1'b1;
        hit_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    active_nxt      = active_r;
    wr_sel          = '0;
    res.accepted    = 1'b0;
    res.matched_slot = '0;
    case (cmd)
      CMD_REGISTER: begin
        if (fields_ok && slot_ok && ((active_r & slot_sel) == '0)) begin
          wr_sel       = slot_sel;
          active_nxt   = active_r | slot_sel;
          res.accepted = 1'b1;
        end
      end
      CMD_UNREGISTER: begin
        if (found) begin
          for (int i = 0; i < VOICES; i++) begin
            if (hit_idx == SLOT_W'(i)) begin
              active_nxt[i] = 1'b0;
            end
          end
          res.accepted     = 1'b1;
          res.matched_slot = hit_idx;
        end
      end
      CMD_CLEAR: begin
        active_nxt   = '0;
        res.accepted = 1'b1;
      end
      default: begin
      end
    endcase
    // report the table as it stands after this command
    res.free_valid  = 1'b0;
    res.free_slot   = '0;
    res.active_mask = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      res.active_mask[i] = active_nxt[i];
      if (!active_nxt[i]) begin
        res.free_valid = 1'b1;
        res.free_slot  = SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (commit) begin
      active_r <= active_nxt;
    end
  end

  // note and channel are only read behind an active bit, so they need no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < VOICES; i++) begin
      if (commit && wr_sel[i]) begin
        note_r[i] <= note_number[NOTE_W-1:0];
        chan_r[i] <= midi_chan[CHAN_W-1:0];
      end
    end
  end

  a_register_adds_one: assert property (@(posedge clk) disable iff (!rst_n)
    commit && cmd == CMD_REGISTER && res.accepted |=>
      $countones(active_r) == $countones($past(active_r)) + 1)
    else $error("accepted register did not claim exactly one slot");

  a_unregister_frees_one: assert property (@(posedge clk) disable iff (!rst_n)
    commit && cmd == CMD_UNREGISTER && res.accepted |=>
      $countones(active_r) + 1 == $countones($past(active_r)))
    else $error("accepted unregister did not free exactly one slot");

  a_refused_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    commit && !res.accepted |=> $stable(active_r))
    else $error("refused command changed the slot table");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    commit && cmd == CMD_CLEAR |=> active_r == '0)
    else $error("clear left slots active");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> $stable(active_r))
    else $error("slot table changed without a command");

endmodule

[hdl/midi_voice_slot_tracker_unit.sv]
// Top level of the MIDI voice slot tracker: input register, slot table, result register.
// Depends on mvst_pkg and mvst_slot_table.
//
//   channel | dir | tdata bits (low to high)
//   in_     | in  | cmd[1:0] note_number[9:2] midi_chan[17:10] voice_slot[25:18], zero pad
//   out_    | out | accepted[0] matched_slot[3:1] free_valid[4] free_slot[7:5]
//           |     | active_mask[15:8]
//
// One beat per cycle sustained while out_tready stays high; both stages are registered.
// The slot lookup and update sit between the input register and the result register.
// Reset (rst_n low, synchronous) empties both registers and frees every slot.
// A stalled result holds both stages; the input register drains whenever the result
// register is free or being taken.
module midi_voice_slot_tracker_unit #(
  parameter int VOICES = mvst_pkg::VOICES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mvst_pkg::IN_DATA_W-1:0]  in_tdata,  // cmd, note_number, midi_chan, voice_slot
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mvst_pkg::OUT_DATA_W-1:0] out_tdata  // accepted, matched_slot, free_valid,
                                                     // free_slot, active_mask
);
  import mvst_pkg::*;

  logic              in_valid_r;
  logic              in_valid_nxt;
  cmd_t              cmd_r;
  logic [BYTE_W-1:0] note_r;
  logic [BYTE_W-1:0] chan_r;
  logic [BYTE_W-1:0] slot_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  res_t              res_r;
  res_t              res;
  logic              advance;
  logic              in_beat;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_beat   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt  = in_beat ? 1'b1 : (advance ? 1'b0 : in_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // capture the beat's fields
  always_ff @(posedge clk) begin
    if (in_beat) begin
      cmd_r  <= cmd_t'(in_tdata[1:0]);
      note_r <= in_tdata[9:2];
      chan_r <= in_tdata[17:10];
      slot_r <= in_tdata[25:18];
    end
  end

  mvst_slot_table #(
    .VOICES(VOICES)
  ) u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .commit      (advance),
    .cmd         (cmd_r),
    .note_number (note_r),
    .midi_chan   (chan_r),
    .voice_slot  (slot_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.active_mask, res_r.free_slot, res_r.free_valid,
                       res_r.matched_slot, res_r.accepted};

endmodule
